// ===== rtl/core/bfsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsc_pkg
// Types, constants and class tests shared by the completeness checker files.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsc_pkg;

   localparam int MAX_ARITY = 6;
   localparam int ARITY_W   = 3;
   localparam int TABLE_W   = 1 << MAX_ARITY;
   localparam int INDEX_W   = MAX_ARITY;
   localparam int CLASS_W   = 5;

   // bit positions of the five Post classes
   localparam int CLS_ZERO   = 0;
   localparam int CLS_ONE    = 1;
   localparam int CLS_DUAL   = 2;
   localparam int CLS_MONO   = 3;
   localparam int CLS_LINEAR = 4;

   typedef logic [ARITY_W-1:0] arity_type;
   typedef logic [TABLE_W-1:0] table_type;
   typedef logic [INDEX_W-1:0] index_type;
   typedef logic [CLASS_W-1:0] class_type;

   localparam class_type CLASS_ALL = '1;

   function automatic arity_type sat_arity(input arity_type k);
      return (k > arity_type'(MAX_ARITY)) ? arity_type'(MAX_ARITY) : k;
   endfunction

   // membership of one function in each class, evaluated for every arity in
   // parallel and then selected by the (saturated) arity
   function automatic class_type post_classes(input arity_type k_raw, input table_type t);
      class_type cand [MAX_ARITY+1];
      arity_type k;
      index_type coef;
      index_type xi;
      index_type up;
      logic      c;
      logic      sd;
      logic      mo;
      logic      li;
      int        n;
      k = sat_arity(k_raw);
      for (int kk = 0; kk <= MAX_ARITY; kk++) begin
         n    = 1 << kk;
         c    = t[0];
         sd   = 1'b1;
         mo   = 1'b1;
         li   = 1'b1;
         coef = '0;
         for (int v = 0; v < kk; v++) begin
            coef[v] = t[index_type'(1 << v)] ^ c;
         end
         for (int x = 0; x < n; x++) begin
            xi = index_type'(x);
            if (t[xi] == t[index_type'(n - 1 - x)]) begin
               sd = 1'b0;
            end
            for (int v = 0; v < kk; v++) begin
               up = xi | index_type'(1 << v);
               if (!xi[v] && t[xi] && !t[up]) begin
                  mo = 1'b0;
               end
            end
            if (((^(xi & coef)) ^ c) != t[xi]) begin
               li = 1'b0;
            end
         end
         cand[kk][CLS_ZERO]   = ~t[0];
         cand[kk][CLS_ONE]    = t[index_type'(n - 1)];
         cand[kk][CLS_DUAL]   = sd;
         cand[kk][CLS_MONO]   = mo;
         cand[kk][CLS_LINEAR] = li;
      end
      return cand[k];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bfsc_if.sv =====
// ----------------------------------------------------------------------------
// bfsc channel interfaces
// Valid/ready channels for function requests and class verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfsc_req_if import bfsc_pkg::*;;
   logic      valid;
   logic      ready;
   arity_type arity;
   table_type truth_table;
   logic      last_in;

   modport source (output valid, output arity, output truth_table, output last_in,
                   input ready);
   modport sink   (input valid, input arity, input truth_table, input last_in,
                   output ready);
endinterface

interface bfsc_rsp_if;
   logic valid;
   logic ready;
   logic keeps_zero;
   logic keeps_one;
   logic self_dual;
   logic monotone;
   logic linear;
   logic set_complete;
   logic last_out;

   modport source (output valid, output keeps_zero, output keeps_one, output self_dual,
                   output monotone, output linear, output set_complete, output last_out,
                   input ready);
   modport sink   (input valid, input keeps_zero, input keeps_one, input self_dual,
                   input monotone, input linear, input set_complete, input last_out,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/boolean_function_set_completeness.sv =====
// ----------------------------------------------------------------------------
// boolean_function_set_completeness
// Post completeness checker over a stream of Boolean functions.
// ----------------------------------------------------------------------------
// Each request carries one function (arity 0..6, 64-bit truth table, last
// marker) and yields exactly one verdict: membership in the 0-preserving,
// 1-preserving, self-dual, monotone and linear classes, plus whether the set
// seen so far (this function included) is functionally complete. Arity above
// six is treated as six; table bits beyond 2^arity are ignored. After a
// request marked last the running class flags go back to all ones. A request
// is registered, classified by one level of parallel logic and registered
// again: its verdict is offered from that second register, and
// one request is taken every cycle while the verdict side keeps up. The only
// serial dependence is the five-bit AND of running flags.
// ----------------------------------------------------------------------------
`default_nettype none

module boolean_function_set_completeness import bfsc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   bfsc_req_if.sink    req_bus,
   bfsc_rsp_if.source  rsp_bus
);

   logic      s1_valid_ff, s1_valid_in;
   arity_type s1_arity_ff;
   table_type s1_table_ff;
   logic      s1_last_ff;

   logic      out_valid_ff, out_valid_in;
   class_type out_class_ff;
   logic      out_complete_ff;
   logic      out_last_ff;

   class_type class_ff, class_in;

   class_type mine;
   class_type merged;
   logic      out_take;
   logic      advance;
   logic      req_ready;
   logic      accept;

   assign out_take  = !out_valid_ff || rsp_bus.ready;
   assign advance   = s1_valid_ff && out_take;
   assign req_ready = !s1_valid_ff || out_take;
   assign accept    = req_bus.valid && req_ready;

   assign mine   = post_classes(s1_arity_ff, s1_table_ff);
   assign merged = class_ff & mine;

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !out_take);
      out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);
      class_in     = class_ff;
      if (advance) begin
         // a finished set starts over with every class still possible
         class_in = s1_last_ff ? CLASS_ALL : merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         class_ff     <= CLASS_ALL;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         class_ff     <= class_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_arity_ff <= req_bus.arity;
         s1_table_ff <= req_bus.truth_table;
         s1_last_ff  <= req_bus.last_in;
      end
      if (advance) begin
         out_class_ff    <= mine;
         out_complete_ff <= (merged == '0);
         out_last_ff     <= s1_last_ff;
      end
   end

   assign req_bus.ready        = req_ready;
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.keeps_zero   = out_class_ff[CLS_ZERO];
   assign rsp_bus.keeps_one    = out_class_ff[CLS_ONE];
   assign rsp_bus.self_dual    = out_class_ff[CLS_DUAL];
   assign rsp_bus.monotone     = out_class_ff[CLS_MONO];
   assign rsp_bus.linear       = out_class_ff[CLS_LINEAR];
   assign rsp_bus.set_complete = out_complete_ff;
   assign rsp_bus.last_out     = out_last_ff;

`ifndef SYNTH
   // flags return to all ones once a set is closed
   a_last_restores: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (class_ff == CLASS_ALL))
      else $error("class flags not restored after last request");

   // within a set the flags can only fall
   a_flags_fall: assert property (@(posedge clock) disable iff (reset)
      (advance && !s1_last_ff) |=> ((class_ff & ~$past(class_ff)) == '0))
      else $error("class flag rose inside a set");

   // a held first stage must block new requests
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_take) |-> !req_bus.ready)
      else $error("request accepted over a stalled stage");

   // a complete verdict means no class survived the merge
   a_complete_clean: assert property (@(posedge clock) disable iff (reset)
      (advance && !s1_last_ff && (merged == '0)) |=> (class_ff == '0))
      else $error("complete verdict with surviving class flag");
`endif

endmodule

`default_nettype wire
